// ===== rtl/core/key_digit_fifo_number_loader_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Key digit FIFO loader assertion macros
// Shared concurrent assertion forms used by the loader RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_DIGIT_FIFO_NUMBER_LOADER_UNIT_MACROS_SVH
`define KEY_DIGIT_FIFO_NUMBER_LOADER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KDF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kdf_pkg.sv =====
// ----------------------------------------------------------------------------
// kdf_pkg
// Sizes, codes and the controller/datapath interface types of the loader.
// ----------------------------------------------------------------------------
package kdf_pkg;

   // storage sizes
   localparam int FIFO_DEPTH    = 16;
   localparam int TABLE_ENTRIES = 16;

   // derived widths
   localparam int SLOT_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int ENTRY_W = $clog2(TABLE_ENTRIES + 1);

   // fixed field widths
   localparam int ACTION_W = 2;
   localparam int CODE_W   = 8;
   localparam int LEVEL_W  = 5;
   localparam int INDEX_W  = 4;
   localparam int VALUE_W  = 64;

   // code constants
   localparam logic [CODE_W-1:0] CODE_MAX   = 8'h15;
   localparam logic [CODE_W-1:0] EMPTY_CODE = 8'hFF;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd3;

   // controller -> datapath commands
   typedef struct packed {
      logic push;         // store code if legal and FIFO not full, report
      logic clear;        // reset pointers and count, report
      logic pop_empty;    // report pop on empty FIFO
      logic pop;          // take oldest, report it
      logic acc_clear;    // start a new fold
      logic fold;         // take oldest, fold into accumulator
      logic commit_done;  // write table entry if room, report
   } kdf_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic empty;
   } kdf_status_type;

endpackage

// ===== rtl/core/kdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kdf_ctrl
// Sequencer: dispatches actions and walks the FIFO during a commit.
// ----------------------------------------------------------------------------
module kdf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kdf_pkg::ACTION_W-1:0]  req_action,
   input  kdf_pkg::kdf_status_type       status_i,
   output kdf_pkg::kdf_cmd_type          cmd_o,
   output logic                          busy
);
   import kdf_pkg::*;

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] S_IDLE    = 2'd0;
   localparam logic [STATE_W-1:0] S_POP     = 2'd1;
   localparam logic [STATE_W-1:0] S_DRN_RD  = 2'd2;
   localparam logic [STATE_W-1:0] S_DRN_ACC = 2'd3;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;
   logic               accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_PUSH: begin
                     cmd_o.push = 1'b1;
                  end
                  ACT_POP: begin
                     if (status_i.empty) begin
                        cmd_o.pop_empty = 1'b1;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  ACT_CLEAR: begin
                     cmd_o.clear = 1'b1;
                  end
                  ACT_COMMIT: begin
                     cmd_o.acc_clear = 1'b1;
                     state_in        = S_DRN_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // read data of the oldest slot is valid now
         S_POP: begin
            cmd_o.pop = 1'b1;
            state_in  = S_IDLE;
         end
         // read port settles on the current oldest slot
         S_DRN_RD: begin
            if (status_i.empty) begin
               cmd_o.commit_done = 1'b1;
               state_in          = S_IDLE;
            end else begin
               state_in = S_DRN_ACC;
            end
         end
         S_DRN_ACC: begin
            cmd_o.fold = 1'b1;
            state_in   = S_DRN_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/kdf_datapath.sv =====
// ----------------------------------------------------------------------------
// kdf_datapath
// Code store, ring pointers, fold accumulator, table slot counter and the
// result registers.
// ----------------------------------------------------------------------------
`include "key_digit_fifo_number_loader_unit_macros.svh"

module kdf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  kdf_pkg::kdf_cmd_type          cmd_i,
   input  logic [kdf_pkg::CODE_W-1:0]    req_key_code,
   output kdf_pkg::kdf_status_type       status_o,
   output logic                          rsp_strobe,
   output logic [kdf_pkg::CODE_W-1:0]    rsp_pop_data,
   output logic                          rsp_push_accepted,
   output logic [kdf_pkg::LEVEL_W-1:0]   rsp_fifo_level,
   output logic                          rsp_entry_written,
   output logic [kdf_pkg::INDEX_W-1:0]   rsp_entry_index,
   output logic [kdf_pkg::VALUE_W-1:0]   rsp_entry_value
);
   import kdf_pkg::*;

   // code store, registered read
   logic [CODE_W-1:0]  mem [FIFO_DEPTH];
   logic [CODE_W-1:0]  rd_data_ff;

   logic [SLOT_W-1:0]  wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ENTRY_W-1:0] next_entry_ff, next_entry_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [CODE_W-1:0]  rsp_pop_data_ff, rsp_pop_data_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_written_ff, rsp_written_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic full;
   logic push_ok;
   logic store_we;
   logic take;
   logic room;

   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign push_ok  = (req_key_code <= CODE_MAX) && !full;
   assign store_we = cmd_i.push && push_ok;
   assign take     = cmd_i.pop || cmd_i.fold;
   assign room     = (next_entry_ff < ENTRY_W'(TABLE_ENTRIES));

   assign status_o.empty = (count_ff == '0);

   // ring pointers, count, accumulator, table slot
   always_comb begin
      wr_slot_in    = wr_slot_ff;
      rd_slot_in    = rd_slot_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      next_entry_in = next_entry_ff;

      if (cmd_i.clear) begin
         wr_slot_in = '0;
         rd_slot_in = '0;
         count_in   = '0;
      end else if (store_we) begin
         wr_slot_in = (wr_slot_ff == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : wr_slot_ff + 1'b1;
         count_in   = count_ff + 1'b1;
      end else if (take) begin
         rd_slot_in = (rd_slot_ff == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : rd_slot_ff + 1'b1;
         count_in   = count_ff - 1'b1;
      end

      // times ten as two shifted adds, plus the digit
      if (cmd_i.acc_clear) begin
         acc_in = '0;
      end else if (cmd_i.fold) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + VALUE_W'(rd_data_ff);
      end

      if (cmd_i.commit_done && room) begin
         next_entry_in = next_entry_ff + 1'b1;
      end
   end

   // result word
   always_comb begin
      rsp_strobe_in   = cmd_i.push || cmd_i.clear || cmd_i.pop_empty ||
                        cmd_i.pop || cmd_i.commit_done;
      rsp_pop_data_in = cmd_i.pop ? rd_data_ff : EMPTY_CODE;
      rsp_accepted_in = store_we;
      rsp_level_in    = LEVEL_W'(count_in);
      rsp_written_in  = cmd_i.commit_done && room;
      rsp_index_in    = rsp_written_in ? INDEX_W'(next_entry_ff) : '0;
      rsp_value_in    = rsp_written_in ? acc_ff : '0;
   end

   // code store
   always_ff @(posedge clock) begin
      if (store_we) begin
         mem[wr_slot_ff] <= req_key_code;
      end
      rd_data_ff <= mem[rd_slot_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff    <= '0;
         rd_slot_ff    <= '0;
         count_ff      <= '0;
         next_entry_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         wr_slot_ff    <= wr_slot_in;
         rd_slot_ff    <= rd_slot_in;
         count_ff      <= count_in;
         next_entry_ff <= next_entry_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (rsp_strobe_in) begin
         rsp_pop_data_ff <= rsp_pop_data_in;
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_level_ff    <= rsp_level_in;
         rsp_written_ff  <= rsp_written_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_value_ff    <= rsp_value_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_pop_data      = rsp_pop_data_ff;
   assign rsp_push_accepted = rsp_accepted_ff;
   assign rsp_fifo_level    = rsp_level_ff;
   assign rsp_entry_written = rsp_written_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_entry_value   = rsp_value_ff;

   // checks
   `KDF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH), "fifo count over depth")
   `KDF_ASSERT_IMPL(a_take_nonempty, clock, reset, take, count_ff != '0, "take from empty fifo")
   `KDF_ASSERT_NEXT(a_pop_legal, clock, reset, cmd_i.pop, rsp_strobe_ff && (rsp_pop_data_ff <= CODE_MAX), "popped code out of range")
   `KDF_ASSERT_NEXT(a_commit_drained, clock, reset, cmd_i.commit_done, rsp_strobe_ff && (rsp_level_ff == '0), "commit left codes held")

endmodule

// ===== rtl/core/key_digit_fifo_number_loader_unit.sv =====
// Push, clear and pop on an empty FIFO: result strobe in the next cycle, busy stays low.
// Pop with data: busy in S_POP, result registered after S_POP (registered store read).
// Commit of N held codes: busy in S_DRN_RD and S_DRN_ACC per code plus a last S_DRN_RD, then
// a registered result; each code costs one store read and one times-ten fold step.
// Synchronous active-high reset empties the FIFO and rewinds the table slot; the store
// itself is not cleared. The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
// key_digit_fifo_number_loader_unit
// Key code FIFO with pop, clear and a commit that folds the held digits into a
// 64-bit number and files it in the next table slot while slots remain.
// ----------------------------------------------------------------------------
module key_digit_fifo_number_loader_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [kdf_pkg::ACTION_W-1:0]  req_action,
   input  logic [kdf_pkg::CODE_W-1:0]    req_key_code,
   output logic                          rsp_strobe,
   output logic [kdf_pkg::CODE_W-1:0]    rsp_pop_data,
   output logic                          rsp_push_accepted,
   output logic [kdf_pkg::LEVEL_W-1:0]   rsp_fifo_level,
   output logic                          rsp_entry_written,
   output logic [kdf_pkg::INDEX_W-1:0]   rsp_entry_index,
   output logic [kdf_pkg::VALUE_W-1:0]   rsp_entry_value
);
   import kdf_pkg::*;

   kdf_cmd_type    cmd;
   kdf_status_type status;

   // sequencer
   kdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status_i   (status),
      .cmd_o      (cmd),
      .busy       (busy)
   );

   // storage and arithmetic
   kdf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .req_key_code      (req_key_code),
      .status_o          (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_pop_data      (rsp_pop_data),
      .rsp_push_accepted (rsp_push_accepted),
      .rsp_fifo_level    (rsp_fifo_level),
      .rsp_entry_written (rsp_entry_written),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_value   (rsp_entry_value)
   );

endmodule
